[rtl/core/waypoint_rotate_then_drive_controller_core_assert.svh]
// Assertion macros shared by the controller core.
`ifndef WAYPOINT_ROTATE_THEN_DRIVE_CONTROLLER_CORE_ASSERT_SVH
`define WAYPOINT_ROTATE_THEN_DRIVE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define WRTD_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wrtd assertion failed");

// Next-cycle implication.
`define WRTD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wrtd assertion failed");

`endif

[rtl/core/wrtd_pkg.sv]
// Shared types, constants and tables of the rotate-then-drive controller.
package wrtd_pkg;

   localparam int COORD_BITS   = 16;
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int CORDIC_W     = DIFF_W + 3;
   localparam int ZACC_W       = 24;
   localparam int ANGLE_W      = 16;
   localparam int CORDIC_STEPS = 14;
   localparam int SUM_W        = 2 * DIFF_W;
   localparam int SQRT_STEPS   = DIFF_W;
   localparam int DIST_W       = DIFF_W;
   localparam int PROD_W       = DIST_W + 8;
   localparam int CNT_W        = 5;
   localparam int ANG_PI       = 12868;
   localparam int ANG_TWO_PI   = 25736;
   localparam int ATAN0_X2     = 1647100;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_TURN  = 2'd1;
   localparam logic [1:0] PHASE_DRIVE = 2'd2;

   localparam logic [2:0] REG_SPEED_GAIN      = 3'd0;
   localparam logic [2:0] REG_SPEED_LIMIT     = 3'd1;
   localparam logic [2:0] REG_ARRIVE_DISTANCE = 3'd2;
   localparam logic [2:0] REG_TURN_STEP       = 3'd3;
   localparam logic [2:0] REG_TURN_SPEED      = 3'd4;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CORDIC_INIT,
      CMD_CORDIC_STEP,
      CMD_HEADING,
      CMD_TICK,
      CMD_SQ_X,
      CMD_SQ_Y,
      CMD_SQRT_STEP,
      CMD_SPEED,
      CMD_OUT_TURN,
      CMD_OUT_DRIVE,
      CMD_OUT_IDLE
   } cmd_type;

   typedef struct packed {
      logic       is_tick;
      logic [1:0] phase;
      logic       target_zero;
      logic       turn_done;
      logic       cordic_last;
      logic       sqrt_last;
   } status_type;

   typedef struct packed {
      logic [7:0]  speed_gain;
      logic [9:0]  speed_limit;
      logic [9:0]  arrive_distance;
      logic [11:0] turn_step;
      logic [9:0]  turn_speed;
   } cfg_type;

   function automatic logic signed [ZACC_W-1:0] atan_q20(input logic [CNT_W-1:0] idx);
      logic signed [ZACC_W-1:0] v;
      case (idx)
         5'd0:    v = 24'sd823550;
         5'd1:    v = 24'sd486170;
         5'd2:    v = 24'sd256879;
         5'd3:    v = 24'sd130396;
         5'd4:    v = 24'sd65451;
         5'd5:    v = 24'sd32757;
         5'd6:    v = 24'sd16383;
         5'd7:    v = 24'sd8192;
         5'd8:    v = 24'sd4096;
         5'd9:    v = 24'sd2048;
         5'd10:   v = 24'sd1024;
         5'd11:   v = 24'sd512;
         5'd12:   v = 24'sd256;
         5'd13:   v = 24'sd128;
         5'd14:   v = 24'sd64;
         5'd15:   v = 24'sd32;
         5'd16:   v = 24'sd16;
         5'd17:   v = 24'sd8;
         5'd18:   v = 24'sd4;
         5'd19:   v = 24'sd2;
         5'd20:   v = 24'sd1;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/wrtd_csr.sv]
// Configuration register file with an APB-style access port.
module wrtd_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output wrtd_pkg::cfg_type   cfg
);
   import wrtd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_SPEED_GAIN:      cfg_in.speed_gain      = csr_pwdata[7:0];
            REG_SPEED_LIMIT:     cfg_in.speed_limit     = csr_pwdata[9:0];
            REG_ARRIVE_DISTANCE: cfg_in.arrive_distance = csr_pwdata[9:0];
            REG_TURN_STEP:       cfg_in.turn_step       = csr_pwdata[11:0];
            REG_TURN_SPEED:      cfg_in.turn_speed      = csr_pwdata[9:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SPEED_GAIN:      csr_prdata = {24'd0, cfg_ff.speed_gain};
         REG_SPEED_LIMIT:     csr_prdata = {22'd0, cfg_ff.speed_limit};
         REG_ARRIVE_DISTANCE: csr_prdata = {22'd0, cfg_ff.arrive_distance};
         REG_TURN_STEP:       csr_prdata = {20'd0, cfg_ff.turn_step};
         REG_TURN_SPEED:      csr_prdata = {22'd0, cfg_ff.turn_speed};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_gain      <= 8'd128;
         cfg_ff.speed_limit     <= 10'd307;
         cfg_ff.arrive_distance <= 10'd26;
         cfg_ff.turn_step       <= 12'd410;
         cfg_ff.turn_speed      <= 10'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/wrtd_dp.sv]
// Datapath: held goal and turn state, CORDIC atan2, distance and speed arithmetic.
module wrtd_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  wrtd_pkg::cmd_type          cmd,
   output wrtd_pkg::status_type       status,
   input  wrtd_pkg::cfg_type          cfg,
   input  logic                       req_type,
   input  logic signed [15:0]         req_goal_x,
   input  logic signed [15:0]         req_goal_y,
   input  logic signed [15:0]         req_pos_x,
   input  logic signed [15:0]         req_pos_y,
   output logic [9:0]                 rsp_linear_speed,
   output logic signed [10:0]         rsp_angular_speed,
   output logic [1:0]                 rsp_phase,
   output logic                       rsp_arrived
);
   import wrtd_pkg::*;

   logic signed [COORD_BITS-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [DIFF_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic                         is_tick_ff, is_tick_in;
   logic signed [CORDIC_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZACC_W-1:0]     cz_ff, cz_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic signed [ANGLE_W-1:0]    last_heading_ff, last_heading_in;
   logic [ANGLE_W-1:0]           target_ff, target_in, elapsed_ff, elapsed_in;
   logic                         left_ff, left_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [SUM_W-1:0]             sum_ff, sum_in, rem_ff, rem_in, res_ff, res_in;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic                         near_ff, near_in;
   logic [9:0]                   lin_ff, lin_in;
   logic signed [10:0]           ang_ff, ang_in;
   logic [1:0]                   ophase_ff, ophase_in;
   logic                         arrived_ff, arrived_in;

   logic signed [COORD_BITS-1:0] goal_x_sel, goal_y_sel;
   logic signed [CORDIC_W-1:0]   dx_ext, dy_ext, xs, ys;
   logic signed [ZACC_W-1:0]     z_round;
   logic signed [ANGLE_W-1:0]    heading;
   logic signed [ANGLE_W:0]      turn_raw, turn_wrap;
   logic [DIFF_W-1:0]            ax, ay;
   logic [ANGLE_W:0]             elapsed_sum;
   logic [ANGLE_W-1:0]           elapsed_sat;
   logic [5:0]                   bit_shift;
   logic [SUM_W-1:0]             sq_bit, trial;
   logic [DIST_W-1:0]            distance;
   logic [DIST_W-1:0]            speed_raw;
   logic signed [10:0]           turn_cmd;

   assign goal_x_sel = req_type ? goal_x_ff : req_goal_x;
   assign goal_y_sel = req_type ? goal_y_ff : req_goal_y;
   assign dx_ext     = CORDIC_W'(dx_ff);
   assign dy_ext     = CORDIC_W'(dy_ff);
   assign xs         = cx_ff >>> count_ff;
   assign ys         = cy_ff >>> count_ff;
   assign z_round    = (cz_ff + ZACC_W'(128)) >>> 8;

   always_comb begin
      if (dx_ff == '0 && dy_ff == '0) begin
         heading = '0;
      end else if (z_round > ZACC_W'(ANG_PI)) begin
         heading = ANGLE_W'(ANG_PI);
      end else if (z_round < -ZACC_W'(ANG_PI)) begin
         heading = -ANGLE_W'(ANG_PI);
      end else begin
         heading = z_round[ANGLE_W-1:0];
      end
      turn_raw = (ANGLE_W+1)'(heading) - (ANGLE_W+1)'(last_heading_ff);
      if (turn_raw > (ANGLE_W+1)'(ANG_PI)) begin
         turn_wrap = turn_raw - (ANGLE_W+1)'(ANG_TWO_PI);
      end else if (turn_raw <= -(ANGLE_W+1)'(ANG_PI)) begin
         turn_wrap = turn_raw + (ANGLE_W+1)'(ANG_TWO_PI);
      end else begin
         turn_wrap = turn_raw;
      end
   end

   assign ax          = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign ay          = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
   assign elapsed_sum = (ANGLE_W+1)'(elapsed_ff) + (ANGLE_W+1)'(cfg.turn_step);
   assign elapsed_sat = elapsed_sum[ANGLE_W] ? '1 : elapsed_sum[ANGLE_W-1:0];
   assign bit_shift   = {CNT_W'(SQRT_STEPS - 1) - count_ff, 1'b0};
   assign sq_bit      = SUM_W'(1) << bit_shift;
   assign trial       = res_ff + sq_bit;
   assign distance    = res_ff[DIST_W-1:0];
   assign speed_raw   = prod_ff[PROD_W-1:8];
   assign turn_cmd    = left_ff ? 11'(cfg.turn_speed) : -11'(cfg.turn_speed);

   assign status.is_tick     = is_tick_ff;
   assign status.phase       = phase_ff;
   assign status.target_zero = (turn_wrap == '0);
   assign status.turn_done   = (elapsed_sat >= target_ff);
   assign status.cordic_last = (count_ff == CNT_W'(CORDIC_STEPS - 1));
   assign status.sqrt_last   = (count_ff == CNT_W'(SQRT_STEPS - 1));

   assign rsp_linear_speed  = lin_ff;
   assign rsp_angular_speed = ang_ff;
   assign rsp_phase         = ophase_ff;
   assign rsp_arrived       = arrived_ff;

   always_comb begin
      goal_x_in       = goal_x_ff;
      goal_y_in       = goal_y_ff;
      dx_in           = dx_ff;
      dy_in           = dy_ff;
      is_tick_in      = is_tick_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      cz_in           = cz_ff;
      count_in        = count_ff;
      last_heading_in = last_heading_ff;
      target_in       = target_ff;
      elapsed_in      = elapsed_ff;
      left_in         = left_ff;
      phase_in        = phase_ff;
      sum_in          = sum_ff;
      rem_in          = rem_ff;
      res_in          = res_ff;
      prod_in         = prod_ff;
      near_in         = near_ff;
      lin_in          = lin_ff;
      ang_in          = ang_ff;
      ophase_in       = ophase_ff;
      arrived_in      = arrived_ff;
      case (cmd)
         CMD_LOAD: begin
            is_tick_in = req_type;
            goal_x_in  = goal_x_sel;
            goal_y_in  = goal_y_sel;
            dx_in      = DIFF_W'(goal_x_sel) - DIFF_W'(req_pos_x);
            dy_in      = DIFF_W'(goal_y_sel) - DIFF_W'(req_pos_y);
         end
         CMD_CORDIC_INIT: begin
            count_in = '0;
            if (!dx_ff[DIFF_W-1]) begin
               cx_in = dx_ext;
               cy_in = dy_ext;
               cz_in = '0;
            end else if (!dy_ff[DIFF_W-1]) begin
               cx_in = dy_ext;
               cy_in = -dx_ext;
               cz_in = ZACC_W'(ATAN0_X2);
            end else begin
               cx_in = -dy_ext;
               cy_in = dx_ext;
               cz_in = -ZACC_W'(ATAN0_X2);
            end
         end
         CMD_CORDIC_STEP: begin
            count_in = count_ff + CNT_W'(1);
            if (cy_ff > 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_q20(count_ff);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_q20(count_ff);
            end
         end
         CMD_HEADING: begin
            last_heading_in = heading;
            left_in         = (turn_wrap > 0);
            target_in       = turn_wrap[ANGLE_W] ? ANGLE_W'(-turn_wrap)
                                                 : turn_wrap[ANGLE_W-1:0];
            elapsed_in      = '0;
         end
         CMD_TICK: begin
            elapsed_in = elapsed_sat;
         end
         CMD_SQ_X: begin
            sum_in = ax * ax;
         end
         CMD_SQ_Y: begin
            rem_in   = sum_ff + ay * ay;
            res_in   = '0;
            count_in = '0;
         end
         CMD_SQRT_STEP: begin
            count_in = count_ff + CNT_W'(1);
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + sq_bit;
            end else begin
               res_in = res_ff >> 1;
            end
         end
         CMD_SPEED: begin
            prod_in = PROD_W'(cfg.speed_gain) * PROD_W'(distance);
            near_in = (distance <= DIST_W'(cfg.arrive_distance));
         end
         CMD_OUT_TURN: begin
            phase_in   = PHASE_TURN;
            lin_in     = '0;
            ang_in     = turn_cmd;
            ophase_in  = PHASE_TURN;
            arrived_in = 1'b0;
         end
         CMD_OUT_DRIVE: begin
            ang_in = '0;
            if (near_ff) begin
               phase_in   = PHASE_IDLE;
               lin_in     = '0;
               ophase_in  = PHASE_IDLE;
               arrived_in = 1'b1;
            end else begin
               phase_in   = PHASE_DRIVE;
               lin_in     = (speed_raw > DIST_W'(cfg.speed_limit)) ? cfg.speed_limit
                                                                   : speed_raw[9:0];
               ophase_in  = PHASE_DRIVE;
               arrived_in = 1'b0;
            end
         end
         CMD_OUT_IDLE: begin
            lin_in     = '0;
            ang_in     = '0;
            ophase_in  = PHASE_IDLE;
            arrived_in = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff       <= '0;
         goal_y_ff       <= '0;
         last_heading_ff <= '0;
         target_ff       <= '0;
         elapsed_ff      <= '0;
         left_ff         <= 1'b0;
         phase_ff        <= PHASE_IDLE;
      end else begin
         goal_x_ff       <= goal_x_in;
         goal_y_ff       <= goal_y_in;
         last_heading_ff <= last_heading_in;
         target_ff       <= target_in;
         elapsed_ff      <= elapsed_in;
         left_ff         <= left_in;
         phase_ff        <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      is_tick_ff <= is_tick_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      count_ff   <= count_in;
      sum_ff     <= sum_in;
      rem_ff     <= rem_in;
      res_ff     <= res_in;
      prod_ff    <= prod_in;
      near_ff    <= near_in;
      lin_ff     <= lin_in;
      ang_ff     <= ang_in;
      ophase_ff  <= ophase_in;
      arrived_ff <= arrived_in;
   end

endmodule

[rtl/core/wrtd_ctrl.sv]
// Controller state machine that sequences the datapath and runs both handshakes.
module wrtd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wrtd_pkg::cmd_type      cmd,
   input  wrtd_pkg::status_type   status
);
   import wrtd_pkg::*;

   `include "waypoint_rotate_then_drive_controller_core_assert.svh"

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_DISPATCH = 11'b000_0000_0010,
      ST_C_STEP   = 11'b000_0000_0100,
      ST_HEADING  = 11'b000_0000_1000,
      ST_TICK     = 11'b000_0001_0000,
      ST_SQ_X     = 11'b000_0010_0000,
      ST_SQ_Y     = 11'b000_0100_0000,
      ST_SQRT     = 11'b000_1000_0000,
      ST_SPEED    = 11'b001_0000_0000,
      ST_RESULT   = 11'b010_0000_0000,
      ST_SPARE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   kind_ff, kind_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = CMD_NONE;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!status.is_tick) begin
               cmd      = CMD_CORDIC_INIT;
               state_in = ST_C_STEP;
            end else if (status.phase == PHASE_TURN) begin
               state_in = ST_TICK;
            end else if (status.phase == PHASE_DRIVE) begin
               state_in = ST_SQ_X;
            end else begin
               kind_in  = CMD_OUT_IDLE;
               state_in = ST_RESULT;
            end
         end
         ST_C_STEP: begin
            cmd = CMD_CORDIC_STEP;
            if (status.cordic_last) begin
               state_in = ST_HEADING;
            end
         end
         ST_HEADING: begin
            cmd = CMD_HEADING;
            if (status.target_zero) begin
               state_in = ST_SQ_X;
            end else begin
               kind_in  = CMD_OUT_TURN;
               state_in = ST_RESULT;
            end
         end
         ST_TICK: begin
            cmd = CMD_TICK;
            if (status.turn_done) begin
               state_in = ST_SQ_X;
            end else begin
               kind_in  = CMD_OUT_TURN;
               state_in = ST_RESULT;
            end
         end
         ST_SQ_X: begin
            cmd      = CMD_SQ_X;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd      = CMD_SQ_Y;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd = CMD_SQRT_STEP;
            if (status.sqrt_last) begin
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            cmd      = CMD_SPEED;
            kind_in  = CMD_OUT_DRIVE;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = kind_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   `WRTD_ASSERT_NEXT(a_pending_result_holds, state_ff == ST_RESULT && rsp_valid_ff && !rsp_ready, state_ff == ST_RESULT)
   `WRTD_ASSERT_NEXT(a_accept_dispatches, req_valid && req_ready, state_ff == ST_DISPATCH)
   `WRTD_ASSERT_NEXT(a_cordic_ends, state_ff == ST_C_STEP && status.cordic_last, state_ff == ST_HEADING)
   `WRTD_ASSERT_SAME(a_result_only_on_free, cmd == CMD_OUT_DRIVE || cmd == CMD_OUT_TURN || cmd == CMD_OUT_IDLE, !rsp_valid_ff || rsp_ready)

endmodule

[rtl/core/waypoint_rotate_then_drive_controller_core.sv]
// Top level of the rotate-then-drive go-to-goal controller.
// Takes one item at a time. A start item runs a 14-iteration CORDIC atan2 and returns its
// turning result; a start with no turn, a tick that finishes a turn and a drive tick also
// run the 17-iteration square root. The next item is taken once the result is registered;
// a result not yet taken only delays the next one.
module waypoint_rotate_then_drive_controller_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic signed [15:0]  req_goal_x,
   input  logic signed [15:0]  req_goal_y,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [9:0]          rsp_linear_speed,
   output logic signed [10:0]  rsp_angular_speed,
   output logic [1:0]          rsp_phase,
   output logic                rsp_arrived,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import wrtd_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   wrtd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wrtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   wrtd_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg),
      .req_type          (req_type),
      .req_goal_x        (req_goal_x),
      .req_goal_y        (req_goal_y),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_angular_speed (rsp_angular_speed),
      .rsp_phase         (rsp_phase),
      .rsp_arrived       (rsp_arrived)
   );

endmodule

[tb/tb.sv]
// Testbench for the rotate-then-drive go-to-goal controller core.
`timescale 1ns / 1ps

module tb;
   import wrtd_pkg::*;

   typedef struct {
      logic [9:0]         lin;
      logic signed [10:0] ang;
      logic [1:0]         ph;
      logic               arr;
   } cmd_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic signed [15:0]  req_goal_x;
   logic signed [15:0]  req_goal_y;
   logic signed [15:0]  req_pos_x;
   logic signed [15:0]  req_pos_y;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [9:0]          rsp_linear_speed;
   logic signed [10:0]  rsp_angular_speed;
   logic [1:0]          rsp_phase;
   logic                rsp_arrived;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [4:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   waypoint_rotate_then_drive_controller_core u_top (.*);

   cmd_result_type expected_cmds[$];
   int          errors = 0;
   int          items_sent = 0;
   bit          calm = 0;
   bit          stall_req = 0;

   // Predictor state and its copy of the registers.
   logic [7:0]  p_gain = 8'd128;
   logic [9:0]  p_limit = 10'd307;
   logic [9:0]  p_arrive = 10'd26;
   logic [11:0] p_step = 12'd410;
   logic [9:0]  p_tspeed = 10'd256;
   longint      p_goal_x = 0;
   longint      p_goal_y = 0;
   int          p_heading = 0;
   int unsigned p_target = 0;
   int unsigned p_elapsed = 0;
   bit          p_left = 0;
   logic [1:0]  p_phase = PHASE_IDLE;

   localparam longint ARCTAN[14] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                     8192, 4096, 2048, 1024, 512, 256, 128};

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int bearing(longint dx, longint dy);
      longint x, y, z, t, xs, ys;
      x = dx;
      y = dy;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = ARCTAN[0] * 2;
         end else begin
            t = x; x = -y; y = t; z = -ARCTAN[0] * 2;
         end
      end
      for (int i = 0; i < 14; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + ARCTAN[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ARCTAN[i];
         end
      end
      z = (z + 128) >>> 8;
      if (z > ANG_PI) z = ANG_PI;
      if (z < -ANG_PI) z = -ANG_PI;
      return int'(z);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic cmd_result_type drive_toward(longint px, longint py);
      cmd_result_type r;
      longint unsigned ax, ay, d, sp;
      ax = (p_goal_x - px < 0) ? px - p_goal_x : p_goal_x - px;
      ay = (p_goal_y - py < 0) ? py - p_goal_y : p_goal_y - py;
      d = int_sqrt(ax * ax + ay * ay);
      r.ang = 0;
      if (d <= p_arrive) begin
         p_phase = PHASE_IDLE;
         r.lin = 0; r.ph = PHASE_IDLE; r.arr = 1;
      end else begin
         sp = (p_gain * d) >> 8;
         if (sp > p_limit) sp = p_limit;
         p_phase = PHASE_DRIVE;
         r.lin = sp[9:0]; r.ph = PHASE_DRIVE; r.arr = 0;
      end
      return r;
   endfunction

   function automatic cmd_result_type turning_cmd();
      cmd_result_type r;
      r.lin = 0;
      r.ang = p_left ? $signed({1'b0, p_tspeed}) : -$signed({1'b0, p_tspeed});
      r.ph = PHASE_TURN;
      r.arr = 0;
      return r;
   endfunction

   function automatic cmd_result_type controller_step(bit is_tick, longint gx, longint gy,
                                                      longint px, longint py);
      cmd_result_type r;
      int h, rot;
      if (!is_tick) begin
         p_goal_x = gx;
         p_goal_y = gy;
         h = bearing(gx - px, gy - py);
         rot = h - p_heading;
         if (rot > ANG_PI) rot = rot - ANG_TWO_PI;
         else if (rot <= -ANG_PI) rot = rot + ANG_TWO_PI;
         p_heading = h;
         p_left = rot > 0;
         p_target = (rot < 0) ? -rot : rot;
         p_elapsed = 0;
         if (p_target > 0) begin
            p_phase = PHASE_TURN;
            r = turning_cmd();
         end else begin
            r = drive_toward(px, py);
         end
      end else if (p_phase == PHASE_TURN) begin
         p_elapsed = p_elapsed + p_step;
         if (p_elapsed > 32'hFFFF) p_elapsed = 32'hFFFF;
         if (p_elapsed < p_target) r = turning_cmd();
         else r = drive_toward(px, py);
      end else if (p_phase == PHASE_DRIVE) begin
         r = drive_toward(px, py);
      end else begin
         r.lin = 0; r.ang = 0; r.ph = PHASE_IDLE; r.arr = 0;
      end
      return r;
   endfunction

   task automatic send_item(bit is_tick, logic signed [15:0] gx, logic signed [15:0] gy,
                            logic signed [15:0] px, logic signed [15:0] py);
      bit seen;
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= is_tick;
      req_goal_x <= gx;
      req_goal_y <= gy;
      req_pos_x <= px;
      req_pos_y <= py;
      do begin
         @(negedge clock);
         seen = req_ready;
         @(posedge clock);
      end while (!seen);
      expected_cmds.push_back(controller_step(is_tick, gx, gy, px, py));
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_SPEED_GAIN:      p_gain = value[7:0];
         REG_SPEED_LIMIT:     p_limit = value[9:0];
         REG_ARRIVE_DISTANCE: p_arrive = value[9:0];
         REG_TURN_STEP:       p_step = value[11:0];
         REG_TURN_SPEED:      p_tspeed = value[9:0];
         default: ;
      endcase
   endtask

   task automatic set_all(int g, int l, int a, int s, int t);
      drain();
      write_reg(REG_SPEED_GAIN, g);
      write_reg(REG_SPEED_LIMIT, l);
      write_reg(REG_ARRIVE_DISTANCE, a);
      write_reg(REG_TURN_STEP, s);
      write_reg(REG_TURN_SPEED, t);
   endtask

   // A start item followed by ticks that close in on the goal.
   task automatic run_route(int span, int ticks);
      logic signed [15:0] gx, gy, sx, sy;
      longint px, py;
      gx = 16'($urandom);
      gy = 16'($urandom);
      sx = $urandom_range(99) < 80 ? gx + $signed(16'($urandom_range(2 * span) - span))
                                   : 16'($urandom);
      sy = $urandom_range(99) < 80 ? gy + $signed(16'($urandom_range(2 * span) - span))
                                   : 16'($urandom);
      send_item(0, gx, gy, sx, sy);
      for (int k = 1; k <= ticks; k++) begin
         px = sx + ((longint'(gx) - sx) * k) / ticks;
         py = sy + ((longint'(gy) - sy) * k) / ticks;
         send_item(1, 16'($urandom), 16'($urandom), 16'(px), 16'(py));
      end
   endtask

   task automatic test_directed();
      send_item(1, 0, 0, 0, 0);
      send_item(1, -1, 32767, -32768, 5);
      send_item(0, 100, 100, 100, 100);
      send_item(0, 32767, 32767, -32768, -32768);
      for (int k = 0; k < 5; k++) send_item(1, 0, 0, -32768, -32768);
      send_item(0, -32768, 0, 0, 0);
      send_item(0, -32768, -1, 0, 0);
      send_item(0, -32768, 1, 0, 0);
      send_item(0, 0, 32767, 0, 0);
      send_item(0, 0, -32768, 0, 0);
      for (int k = 0; k < 30; k++) send_item(1, 0, 0, 0, -32700);
      send_item(1, 0, 0, 0, -32768);
      send_item(1, 0, 0, 0, -32768);
      send_item(0, 0, -32768, 0, 0);
      send_item(0, 500, 0, 0, 0);
      send_item(1, 0, 0, 480, 0);
   endtask

   task automatic test_config_sweep();
      set_all(0, 0, 0, 1, 0);
      run_route(3000, 8);
      set_all(255, 1023, 1023, 4095, 1023);
      run_route(3000, 6);
      run_route(200, 4);
      set_all(255, 1023, 0, 4095, 1023);
      run_route(32767, 10);
      set_all(128, 307, 26, 410, 256);
      run_route(2000, 40);
   endtask

   task automatic test_random();
      while (items_sent < 700) begin
         if ($urandom_range(99) < 4) begin
            set_all($urandom_range(255), $urandom_range(1023), $urandom_range(300),
                    $urandom_range(1, 4095), $urandom_range(1023));
         end
         calm = (items_sent % 200) > 150;
         if ($urandom_range(99) < 80) begin
            run_route($urandom_range(20, 8000), $urandom_range(1, 40));
         end else begin
            send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
         end
      end
      calm = 0;
   endtask

   task automatic test_backpressure();
      drain();
      write_reg(REG_TURN_STEP, 4095);
      stall_req = 1;
      run_route(3000, 20);
      drain();
      run_route(3000, 10);
      drain();
      run_route(500, 10);
   endtask

   always @(posedge clock) begin
      if (stall_req) begin
         rsp_ready <= 0;
         repeat (400) @(posedge clock);
         stall_req = 0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   always @(negedge clock) begin
      cmd_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cmds.size() == 0) begin
            $error("result with no expected item");
            errors++;
         end else begin
            e = expected_cmds.pop_front();
            if (rsp_linear_speed !== e.lin) begin
               $error("linear_speed expected %0d actual %0d", e.lin, rsp_linear_speed);
               errors++;
            end
            if (rsp_angular_speed !== e.ang) begin
               $error("angular_speed expected %0d actual %0d", e.ang, rsp_angular_speed);
               errors++;
            end
            if (rsp_phase !== e.ph) begin
               $error("phase expected %0d actual %0d", e.ph, rsp_phase);
               errors++;
            end
            if (rsp_arrived !== e.arr) begin
               $error("arrived expected %0d actual %0d", e.arr, rsp_arrived);
               errors++;
            end
         end
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_type = 0;
      req_goal_x = 0;
      req_goal_y = 0;
      req_pos_x = 0;
      req_pos_y = 0;
      rsp_ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/wrtd_pkg.sv
rtl/core/wrtd_csr.sv
rtl/core/wrtd_dp.sv
rtl/core/wrtd_ctrl.sv
rtl/core/waypoint_rotate_then_drive_controller_core.sv
tb/tb.sv
